// ----- hdl/uvs_pkg.sv -----
`default_nettype none

package uvs_pkg;

   // Field and register widths
   localparam int INDEX_BITS  = 10;
   localparam int RADIUS_BITS = 16;
   localparam int POS_BITS    = 17;
   localparam int NORM_BITS   = 16;
   localparam int TEX_BITS    = 16;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_FIELD_BITS = 2 * INDEX_BITS;
   localparam int REQ_BITS       = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 3 * POS_BITS + 3 * NORM_BITS + 2 * TEX_BITS;
   localparam int RSP_BITS       = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Register file
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = RADIUS_BITS;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RADIUS  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SECTORS = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STACKS  = 2'd2;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET  = 16'd256;
   localparam logic [INDEX_BITS-1:0]  SECTORS_RESET = INDEX_BITS'(36);
   localparam logic [INDEX_BITS-1:0]  STACKS_RESET  = INDEX_BITS'(18);

   // Pipelined divider: quotient below 2^33, four quotient bits per stage
   localparam int DIV_LANES     = 4;
   localparam int DIV_QUO_BITS  = 33;
   localparam int DIV_NUM_BITS  = INDEX_BITS + DIV_QUO_BITS;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = (DIV_QUO_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int DIV_LANE_PH_V = 0;
   localparam int DIV_LANE_PH_U = 1;
   localparam int DIV_LANE_TX_S = 2;
   localparam int DIV_LANE_TX_T = 3;

   // Pipelined CORDIC, two micro-rotations per stage
   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORDIC_MAX_ITER   = 24;
   localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > CORDIC_MAX_ITER) ?
                                      CORDIC_MAX_ITER : CORDIC_ITERATIONS;
   localparam int CORDIC_PER_STAGE  = 2;
   localparam int CORDIC_STAGES     = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;
   localparam int CORDIC_LAT        = CORDIC_STAGES + 2;
   localparam int CORDIC_LANES      = 2;
   localparam int CORDIC_W          = 34;
   localparam int PHASE_BITS        = 32;
   localparam int SC_BITS           = 32;
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = CORDIC_W'(652032875);

   localparam int POS_LIM  = 65535;
   localparam int NORM_LIM = 16384;

   // Arctangent of 2^-k in 2^-32 turn units
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input int k);
      logic signed [CORDIC_W-1:0] a;
      case (k)
         0:  a = CORDIC_W'(536870912);
         1:  a = CORDIC_W'(316933406);
         2:  a = CORDIC_W'(167458907);
         3:  a = CORDIC_W'(85004756);
         4:  a = CORDIC_W'(42667331);
         5:  a = CORDIC_W'(21354465);
         6:  a = CORDIC_W'(10679838);
         7:  a = CORDIC_W'(5340245);
         8:  a = CORDIC_W'(2670163);
         9:  a = CORDIC_W'(1335087);
         10: a = CORDIC_W'(667544);
         11: a = CORDIC_W'(333772);
         12: a = CORDIC_W'(166886);
         13: a = CORDIC_W'(83443);
         14: a = CORDIC_W'(41722);
         15: a = CORDIC_W'(20861);
         16: a = CORDIC_W'(10430);
         17: a = CORDIC_W'(5215);
         18: a = CORDIC_W'(2608);
         19: a = CORDIC_W'(1304);
         20: a = CORDIC_W'(652);
         21: a = CORDIC_W'(326);
         22: a = CORDIC_W'(163);
         23: a = CORDIC_W'(81);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/uvs_div.sv -----
`default_nettype none

module uvs_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_vld,
   input  wire logic [uvs_pkg::DIV_NUM_BITS-1:0]  num [uvs_pkg::DIV_LANES],
   input  wire logic [uvs_pkg::INDEX_BITS-1:0]    den [uvs_pkg::DIV_LANES],
   output logic                                   out_vld,
   output logic [uvs_pkg::DIV_QUO_BITS-1:0]       quo [uvs_pkg::DIV_LANES]
);
   import uvs_pkg::*;

   logic [INDEX_BITS-1:0]   rem_ff  [DIV_STAGES][DIV_LANES];
   logic [DIV_QUO_BITS-1:0] bits_ff [DIV_STAGES][DIV_LANES];
   logic [DIV_QUO_BITS-1:0] quo_ff  [DIV_STAGES][DIV_LANES];
   logic [INDEX_BITS-1:0]   den_ff  [DIV_STAGES][DIV_LANES];
   logic                    vld_ff  [DIV_STAGES];

   logic [INDEX_BITS-1:0]   src_rem  [DIV_STAGES][DIV_LANES];
   logic [DIV_QUO_BITS-1:0] src_bits [DIV_STAGES][DIV_LANES];
   logic [DIV_QUO_BITS-1:0] src_quo  [DIV_STAGES][DIV_LANES];
   logic [INDEX_BITS-1:0]   src_den  [DIV_STAGES][DIV_LANES];

   logic [INDEX_BITS-1:0]   rem_in  [DIV_STAGES][DIV_LANES];
   logic [DIV_QUO_BITS-1:0] bits_in [DIV_STAGES][DIV_LANES];
   logic [DIV_QUO_BITS-1:0] quo_in  [DIV_STAGES][DIV_LANES];

   // Restoring division, four quotient bits per stage
   always_comb begin
      logic [INDEX_BITS:0]     t;
      logic [INDEX_BITS-1:0]   r;
      logic [DIV_QUO_BITS-1:0] b;
      logic [DIV_QUO_BITS-1:0] q;
      t = '0;
      for (int l = 0; l < DIV_LANES; l++) begin
         src_rem[0][l]  = num[l][DIV_NUM_BITS-1 -: INDEX_BITS];
         src_bits[0][l] = num[l][DIV_QUO_BITS-1:0];
         src_quo[0][l]  = '0;
         src_den[0][l]  = den[l];
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            src_rem[s][l]  = rem_ff[s-1][l];
            src_bits[s][l] = bits_ff[s-1][l];
            src_quo[s][l]  = quo_ff[s-1][l];
            src_den[s][l]  = den_ff[s-1][l];
         end
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            r = src_rem[s][l];
            b = src_bits[s][l];
            q = src_quo[s][l];
            for (int k = 0; k < DIV_PER_STAGE; k++) begin
               if (s * DIV_PER_STAGE + k < DIV_QUO_BITS) begin
                  t = {r, b[DIV_QUO_BITS-1]};
                  b = {b[DIV_QUO_BITS-2:0], 1'b0};
                  if (t >= {1'b0, src_den[s][l]}) begin
                     r = INDEX_BITS'(t - {1'b0, src_den[s][l]});
                     q = {q[DIV_QUO_BITS-2:0], 1'b1};
                  end else begin
                     r = t[INDEX_BITS-1:0];
                     q = {q[DIV_QUO_BITS-2:0], 1'b0};
                  end
               end
            end
            rem_in[s][l]  = r;
            bits_in[s][l] = b;
            quo_in[s][l]  = q;
         end
      end
   end

   // Advance all stages together; hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < DIV_LANES; l++) begin
               rem_ff[s][l]  <= rem_in[s][l];
               bits_ff[s][l] <= bits_in[s][l];
               quo_ff[s][l]  <= quo_in[s][l];
               den_ff[s][l]  <= src_den[s][l];
            end
         end
      end
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int s = 1; s < DIV_STAGES; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   assign out_vld = vld_ff[DIV_STAGES-1];
   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) quo[l] = quo_ff[DIV_STAGES-1][l];
   end

endmodule

`default_nettype wire

// ----- hdl/uvs_cordic.sv -----
`default_nettype none

module uvs_cordic (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_vld,
   input  wire logic [uvs_pkg::PHASE_BITS-1:0]      phase [uvs_pkg::CORDIC_LANES],
   output logic                                     out_vld,
   output logic signed [uvs_pkg::SC_BITS-1:0]       cos_out [uvs_pkg::CORDIC_LANES],
   output logic signed [uvs_pkg::SC_BITS-1:0]       sin_out [uvs_pkg::CORDIC_LANES]
);
   import uvs_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [CORDIC_STAGES+1][CORDIC_LANES];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_STAGES+1][CORDIC_LANES];
   logic signed [CORDIC_W-1:0] z_ff [CORDIC_STAGES+1][CORDIC_LANES];
   logic [1:0]                 q_ff [CORDIC_STAGES+1][CORDIC_LANES];
   logic                       vld_ff [CORDIC_LAT];
   logic signed [SC_BITS-1:0]  cos_ff [CORDIC_LANES];
   logic signed [SC_BITS-1:0]  sin_ff [CORDIC_LANES];

   logic signed [CORDIC_W-1:0] z0_in [CORDIC_LANES];
   logic [1:0]                 q0_in [CORDIC_LANES];
   logic signed [CORDIC_W-1:0] x_in [CORDIC_STAGES][CORDIC_LANES];
   logic signed [CORDIC_W-1:0] y_in [CORDIC_STAGES][CORDIC_LANES];
   logic signed [CORDIC_W-1:0] z_in [CORDIC_STAGES][CORDIC_LANES];
   logic signed [SC_BITS-1:0]  cos_in [CORDIC_LANES];
   logic signed [SC_BITS-1:0]  sin_in [CORDIC_LANES];

   // Reduce phase to a quadrant and a residual within one eighth turn
   always_comb begin
      logic [PHASE_BITS-1:0] sum;
      logic [PHASE_BITS-1:0] res;
      for (int l = 0; l < CORDIC_LANES; l++) begin
         sum      = phase[l] + 32'h2000_0000;
         q0_in[l] = sum[PHASE_BITS-1 -: 2];
         res      = phase[l] - {q0_in[l], 30'd0};
         z0_in[l] = {{(CORDIC_W-PHASE_BITS){res[PHASE_BITS-1]}}, res};
      end
   end

   // Micro-rotations, two per stage
   always_comb begin
      logic signed [CORDIC_W-1:0] x, y, z, dx, dy;
      dx = '0;
      dy = '0;
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         for (int l = 0; l < CORDIC_LANES; l++) begin
            x = x_ff[s][l];
            y = y_ff[s][l];
            z = z_ff[s][l];
            for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
               if (s * CORDIC_PER_STAGE + k < CORDIC_STEPS) begin
                  dx = y >>> (s * CORDIC_PER_STAGE + k);
                  dy = x >>> (s * CORDIC_PER_STAGE + k);
                  if (!z[CORDIC_W-1]) begin
                     x = x - dx;
                     y = y + dy;
                     z = z - atan_turn(s * CORDIC_PER_STAGE + k);
                  end else begin
                     x = x + dx;
                     y = y - dy;
                     z = z + atan_turn(s * CORDIC_PER_STAGE + k);
                  end
               end
            end
            x_in[s][l] = x;
            y_in[s][l] = y;
            z_in[s][l] = z;
         end
      end
   end

   // Map the rotated vector back to its quadrant
   always_comb begin
      logic signed [CORDIC_W-1:0] xf, yf, c, sn;
      for (int l = 0; l < CORDIC_LANES; l++) begin
         xf = x_ff[CORDIC_STAGES][l];
         yf = y_ff[CORDIC_STAGES][l];
         case (q_ff[CORDIC_STAGES][l])
            2'd0:    begin c = xf;  sn = yf;  end
            2'd1:    begin c = -yf; sn = xf;  end
            2'd2:    begin c = -xf; sn = -yf; end
            default: begin c = yf;  sn = -xf; end
         endcase
         cos_in[l] = c[SC_BITS-1:0];
         sin_in[l] = sn[SC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < CORDIC_LANES; l++) begin
            x_ff[0][l] <= GAIN_Q30;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= z0_in[l];
            q_ff[0][l] <= q0_in[l];
            for (int s = 0; s < CORDIC_STAGES; s++) begin
               x_ff[s+1][l] <= x_in[s][l];
               y_ff[s+1][l] <= y_in[s][l];
               z_ff[s+1][l] <= z_in[s][l];
               q_ff[s+1][l] <= q_ff[s][l];
            end
            cos_ff[l] <= cos_in[l];
            sin_ff[l] <= sin_in[l];
         end
      end
      if (reset) begin
         for (int s = 0; s < CORDIC_LAT; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int s = 1; s < CORDIC_LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   assign out_vld = vld_ff[CORDIC_LAT-1];
   always_comb begin
      for (int l = 0; l < CORDIC_LANES; l++) begin
         cos_out[l] = cos_ff[l];
         sin_out[l] = sin_ff[l];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/uv_sphere_vertex_generator.sv -----
// UV sphere vertex generator.
// Input stream (req_): one beat per vertex, giving a stack index (latitude ring,
// 0 at the north pole) and a sector index (longitude). Indices above the
// configured counts are clamped to the count.
// Output stream (rsp_): one beat per input beat, in order, with position
// (signed Q8.8), unit normal (signed Q1.14) and texture coordinates (Q1.15).
// Config port (csr_): radius, sector count and stack count, written while the
// pipeline is empty; a write takes effect on the next clock edge.
// From the input beat to the output beat the pipeline has one input stage,
// 9 stages of a 4-lane restoring divider (4 quotient bits each) that turn the
// indices into phases and texture coordinates, 10 stages of a two-lane CORDIC
// (phase reduction, eight stages of two micro-rotations each and the quadrant
// mapping), three multiply and round stages and the output register.
// Throughput is one vertex per cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and req_tready drops in
// the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the default radius 1.0, 36 sectors and
// 18 stacks.
`default_nettype none

module uv_sphere_vertex_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // stack_index, sector_index
   input  wire logic [uvs_pkg::REQ_BITS-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t
   output logic [uvs_pkg::RSP_BITS-1:0]              rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [uvs_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [uvs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import uvs_pkg::*;

   localparam int PROD_BITS  = 2 * SC_BITS;
   localparam int XY_BITS    = PROD_BITS - 30;
   localparam int MUL_BITS   = RADIUS_BITS + 1 + XY_BITS;
   localparam int POS_R_BITS = MUL_BITS - 30;
   localparam int NORM_R_BITS = XY_BITS - 16;

   function automatic logic signed [POS_BITS-1:0] sat_pos(
      input logic signed [POS_R_BITS-1:0] v);
      logic signed [POS_BITS-1:0] r;
      if (v > POS_R_BITS'(POS_LIM))        r = POS_BITS'(POS_LIM);
      else if (v < -POS_R_BITS'(POS_LIM))  r = -POS_BITS'(POS_LIM);
      else                                 r = v[POS_BITS-1:0];
      return r;
   endfunction

   function automatic logic signed [NORM_BITS-1:0] sat_norm(
      input logic signed [NORM_R_BITS-1:0] v);
      logic signed [NORM_BITS-1:0] r;
      if (v > NORM_R_BITS'(NORM_LIM))       r = NORM_BITS'(NORM_LIM);
      else if (v < -NORM_R_BITS'(NORM_LIM)) r = -NORM_BITS'(NORM_LIM);
      else                                  r = v[NORM_BITS-1:0];
      return r;
   endfunction

   // Config registers
   logic [RADIUS_BITS-1:0] radius_ff;
   logic [INDEX_BITS-1:0]  sectors_ff;
   logic [INDEX_BITS-1:0]  stacks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RESET;
         sectors_ff <= SECTORS_RESET;
         stacks_ff  <= STACKS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RADIUS:  radius_ff  <= csr_wdata[RADIUS_BITS-1:0];
            CSR_SECTORS: sectors_ff <= csr_wdata[INDEX_BITS-1:0];
            CSR_STACKS:  stacks_ff  <= csr_wdata[INDEX_BITS-1:0];
            default:     ;
         endcase
      end
   end

   // Whole pipeline advances when the output register is free or drained
   logic en;
   logic out_vld_ff;
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // Input stage: clamp indices, force zero counts to one
   logic [INDEX_BITS-1:0] sc_in, st_in, i_in, j_in;
   logic [INDEX_BITS-1:0] sc_ff, st_ff, i_ff, j_ff;
   logic                  vld0_ff;

   always_comb begin
      sc_in = (sectors_ff == '0) ? INDEX_BITS'(1) : sectors_ff;
      st_in = (stacks_ff == '0) ? INDEX_BITS'(1) : stacks_ff;
      i_in  = req_tdata[INDEX_BITS-1:0];
      j_in  = req_tdata[2*INDEX_BITS-1:INDEX_BITS];
      if (i_in > st_in) i_in = st_in;
      if (j_in > sc_in) j_in = sc_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff <= sc_in;
         st_ff <= st_in;
         i_ff  <= i_in;
         j_ff  <= j_in;
      end
      if (reset)   vld0_ff <= 1'b0;
      else if (en) vld0_ff <= req_tvalid;
   end

   // Rounded ratios: two phases and two texture coordinates
   logic [DIV_NUM_BITS-1:0] div_num [DIV_LANES];
   logic [INDEX_BITS-1:0]   div_den [DIV_LANES];
   logic [DIV_QUO_BITS-1:0] div_quo [DIV_LANES];
   logic                    div_vld;

   always_comb begin
      div_num[DIV_LANE_PH_V] = (DIV_NUM_BITS'(j_ff) << 32) + DIV_NUM_BITS'(sc_ff >> 1);
      div_den[DIV_LANE_PH_V] = sc_ff;
      div_num[DIV_LANE_PH_U] = (DIV_NUM_BITS'(i_ff) << 31) + DIV_NUM_BITS'(st_ff >> 1);
      div_den[DIV_LANE_PH_U] = st_ff;
      div_num[DIV_LANE_TX_S] = (DIV_NUM_BITS'(j_ff) << 15) + DIV_NUM_BITS'(sc_ff >> 1);
      div_den[DIV_LANE_TX_S] = sc_ff;
      div_num[DIV_LANE_TX_T] = (DIV_NUM_BITS'(i_ff) << 15) + DIV_NUM_BITS'(st_ff >> 1);
      div_den[DIV_LANE_TX_T] = st_ff;
   end

   uvs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (vld0_ff),
      .num     (div_num),
      .den     (div_den),
      .out_vld (div_vld),
      .quo     (div_quo)
   );

   // Sine and cosine of both angles; lane 0 is the stack angle
   logic [PHASE_BITS-1:0]     phase [CORDIC_LANES];
   logic signed [SC_BITS-1:0] cs_cos [CORDIC_LANES];
   logic signed [SC_BITS-1:0] cs_sin [CORDIC_LANES];
   logic                      cs_vld;

   assign phase[0] = 32'h4000_0000 - div_quo[DIV_LANE_PH_U][PHASE_BITS-1:0];
   assign phase[1] = div_quo[DIV_LANE_PH_V][PHASE_BITS-1:0];

   uvs_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (div_vld),
      .phase   (phase),
      .out_vld (cs_vld),
      .cos_out (cs_cos),
      .sin_out (cs_sin)
   );

   // Carry texture coordinates alongside the CORDIC
   logic [TEX_BITS-1:0] tex_s_dly_ff [CORDIC_LAT];
   logic [TEX_BITS-1:0] tex_t_dly_ff [CORDIC_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         tex_s_dly_ff[0] <= div_quo[DIV_LANE_TX_S][TEX_BITS-1:0];
         tex_t_dly_ff[0] <= div_quo[DIV_LANE_TX_T][TEX_BITS-1:0];
         for (int s = 1; s < CORDIC_LAT; s++) begin
            tex_s_dly_ff[s] <= tex_s_dly_ff[s-1];
            tex_t_dly_ff[s] <= tex_t_dly_ff[s-1];
         end
      end
   end

   // Stage M1: cos u times cos v and sin v
   logic signed [PROD_BITS-1:0] pcc_ff, pcs_ff;
   logic signed [SC_BITS-1:0]   su_m1_ff;
   logic [TEX_BITS-1:0]         tex_s_m1_ff, tex_t_m1_ff;
   logic                        m1_vld_ff;

   // Stage M2: round products to Q30
   logic signed [PROD_BITS-1:0] pcc_rnd, pcs_rnd;
   logic signed [XY_BITS-1:0]   px_ff, py_ff, su_m2_ff;
   logic [TEX_BITS-1:0]         tex_s_m2_ff, tex_t_m2_ff;
   logic                        m2_vld_ff;

   // Stage M3: scale by radius, round normals
   logic signed [MUL_BITS-1:0]  mx_ff, my_ff, mz_ff;
   logic signed [XY_BITS-1:0]   nx_rnd, ny_rnd, nz_rnd;
   logic signed [NORM_BITS-1:0] nx_ff, ny_ff, nz_ff;
   logic [TEX_BITS-1:0]         tex_s_m3_ff, tex_t_m3_ff;
   logic signed [RADIUS_BITS:0] radius_s;
   logic                        m3_vld_ff;

   // Output register
   logic signed [MUL_BITS-1:0]  mx_rnd, my_rnd, mz_rnd;
   logic signed [POS_BITS-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [NORM_BITS-1:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic [TEX_BITS-1:0]         tex_s_ff, tex_t_ff;

   assign pcc_rnd  = pcc_ff + PROD_BITS'(64'sd536870912);
   assign pcs_rnd  = pcs_ff + PROD_BITS'(64'sd536870912);
   assign radius_s = signed'({1'b0, radius_ff});
   assign nx_rnd   = px_ff + XY_BITS'(32768);
   assign ny_rnd   = py_ff + XY_BITS'(32768);
   assign nz_rnd   = su_m2_ff + XY_BITS'(32768);
   assign mx_rnd   = mx_ff + MUL_BITS'(536870912);
   assign my_rnd   = my_ff + MUL_BITS'(536870912);
   assign mz_rnd   = mz_ff + MUL_BITS'(536870912);

   always_ff @(posedge clock) begin
      if (en) begin
         pcc_ff      <= PROD_BITS'(cs_cos[0]) * PROD_BITS'(cs_cos[1]);
         pcs_ff      <= PROD_BITS'(cs_cos[0]) * PROD_BITS'(cs_sin[1]);
         su_m1_ff    <= cs_sin[0];
         tex_s_m1_ff <= tex_s_dly_ff[CORDIC_LAT-1];
         tex_t_m1_ff <= tex_t_dly_ff[CORDIC_LAT-1];

         px_ff       <= pcc_rnd[PROD_BITS-1:30];
         py_ff       <= pcs_rnd[PROD_BITS-1:30];
         su_m2_ff    <= XY_BITS'(su_m1_ff);
         tex_s_m2_ff <= tex_s_m1_ff;
         tex_t_m2_ff <= tex_t_m1_ff;

         mx_ff       <= MUL_BITS'(radius_s) * MUL_BITS'(px_ff);
         my_ff       <= MUL_BITS'(radius_s) * MUL_BITS'(py_ff);
         mz_ff       <= MUL_BITS'(radius_s) * MUL_BITS'(su_m2_ff);
         nx_ff       <= sat_norm(nx_rnd[XY_BITS-1:16]);
         ny_ff       <= sat_norm(ny_rnd[XY_BITS-1:16]);
         nz_ff       <= sat_norm(nz_rnd[XY_BITS-1:16]);
         tex_s_m3_ff <= tex_s_m2_ff;
         tex_t_m3_ff <= tex_t_m2_ff;

         pos_x_ff    <= sat_pos(mx_rnd[MUL_BITS-1:30]);
         pos_y_ff    <= sat_pos(my_rnd[MUL_BITS-1:30]);
         pos_z_ff    <= sat_pos(mz_rnd[MUL_BITS-1:30]);
         norm_x_ff   <= nx_ff;
         norm_y_ff   <= ny_ff;
         norm_z_ff   <= nz_ff;
         tex_s_ff    <= tex_s_m3_ff;
         tex_t_ff    <= tex_t_m3_ff;
      end
      if (reset) begin
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         m3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff  <= cs_vld;
         m2_vld_ff  <= m1_vld_ff;
         m3_vld_ff  <= m2_vld_ff;
         out_vld_ff <= m3_vld_ff;
      end
   end

   // Pack the result beat
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_BITS-RSP_FIELD_BITS){1'b0}},
                        tex_t_ff, tex_s_ff,
                        norm_z_ff, norm_y_ff, norm_x_ff,
                        pos_z_ff, pos_y_ff, pos_x_ff};

endmodule

`default_nettype wire

// ----- hdl/uvs_checker.sv -----
`default_nettype none

module uvs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [uvs_pkg::RSP_BITS-1:0]      rsp_tdata
);
   import uvs_pkg::*;

   localparam int NX_LO = 3 * POS_BITS;
   localparam int TS_LO = 3 * POS_BITS + 3 * NORM_BITS;
   localparam int TT_LO = TS_LO + TEX_BITS;

   // Hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // Input backpressure follows output backpressure
   a_stall_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   // Texture coordinates stay within one
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[TS_LO +: TEX_BITS] <= TEX_BITS'(32768) &&
                     rsp_tdata[TT_LO +: TEX_BITS] <= TEX_BITS'(32768))
      else $error("texture coordinate out of range");

   // Normal x saturates to unit length
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[NX_LO +: NORM_BITS]) <= NORM_BITS'(NORM_LIM) &&
                     $signed(rsp_tdata[NX_LO +: NORM_BITS]) >= -NORM_BITS'(NORM_LIM))
      else $error("normal out of range");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

`default_nettype wire
